>>> hw/rtl/pipc_pkg.sv
// shared types, constants and helpers for the point-in-polygon crossing block
`default_nettype none
package pipc_pkg;

   // coordinate and arithmetic widths
   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int NUM_W   = PROD_W + 1;
   localparam int COUNT_W = 8;

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // configuration register indexes
   typedef enum logic [0:0] {
      REG_REFERENCE_X = 1'b0,
      REG_REFERENCE_Y = 1'b1
   } csr_reg_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH,
      ST_RESULT
   } state_type;

   // request beat
   typedef struct packed {
      logic                      command;
      logic [3:0]                polygon_number;
      logic [6:0]                vertex_number;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
   } req_type;

   // result beat
   typedef struct packed {
      logic               inside_res;
      logic [COUNT_W-1:0] crossing_count;
   } rsp_type;

   // one polygon edge, start p and end q
   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] qx;
      logic signed [COORD_W-1:0] qy;
   } edge_type;

   // query point and reference point
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] rx;
      logic signed [COORD_W-1:0] ry;
   } query_type;

   // 0 < n/d <= 1 by sign-aware compare
   function automatic logic ratio_ok(input logic signed [NUM_W-1:0] n,
                                     input logic signed [NUM_W-1:0] d);
      logic ok;
      if (n == '0) begin
         ok = 1'b0;
      end else if (!d[NUM_W-1]) begin
         ok = !n[NUM_W-1] && (n <= d);
      end else begin
         ok = n[NUM_W-1] && (d <= n);
      end
      return ok;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/point_in_polygon_crossing_top.sv
// polygon store, vertex walk sequencer and crossing counter
// a load is written when it is taken; a query whose point is inside the box
//   answers once all n of its edges are tested, n its vertex count
// throughput: one query at a time, bounded by one vertex memory read per cycle
// queries outside the box, on an unknown polygon or with no vertices answer the cycle after
// reset clears the box and count tables and the reference point; vertex memory is not cleared
`default_nettype none
module point_in_polygon_crossing_top
   import pipc_pkg::*;
#(
   parameter int MAX_VERTICES = 128,
   parameter int MAX_POLYGONS = 16
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire req_type             req_data,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [0:0]          csr_index,
   input  wire logic [COORD_W-1:0]  csr_wdata
);

   localparam int PIDX_W = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int DEPTH  = MAX_POLYGONS * MAX_VERTICES;
   localparam int ADDR_W = $clog2(DEPTH);

   // configuration registers
   logic signed [COORD_W-1:0] ref_x_ff, ref_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_REFERENCE_X: ref_x_ff <= csr_wdata;
            REG_REFERENCE_Y: ref_y_ff <= csr_wdata;
            default:         ref_y_ff <= csr_wdata;
         endcase
      end
   end

   // request decode
   state_type            state_ff, state_in;
   logic                 accept, is_query, p_ok, v_ok, in_box, query_go;
   logic [PIDX_W-1:0]    p_idx;
   logic [ADDR_W-1:0]    base_sel, wr_addr;
   logic [CNT_W-1:0]     n_sel;

   logic signed [COORD_W-1:0] box_min_x_ff [MAX_POLYGONS];
   logic signed [COORD_W-1:0] box_max_x_ff [MAX_POLYGONS];
   logic signed [COORD_W-1:0] box_min_y_ff [MAX_POLYGONS];
   logic signed [COORD_W-1:0] box_max_y_ff [MAX_POLYGONS];
   logic [CNT_W-1:0]          count_tbl_ff [MAX_POLYGONS];

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign is_query = (req_data.command == CMD_QUERY);
   assign p_ok     = 32'(req_data.polygon_number) < MAX_POLYGONS;
   assign v_ok     = 32'(req_data.vertex_number) < MAX_VERTICES;
   assign p_idx    = PIDX_W'(req_data.polygon_number);
   assign n_sel    = count_tbl_ff[p_idx];
   assign base_sel = ADDR_W'(p_idx) * ADDR_W'(MAX_VERTICES);
   assign wr_addr  = base_sel + ADDR_W'(req_data.vertex_number);
   assign in_box   = (box_min_x_ff[p_idx] < req_data.coord_x)
                  && (req_data.coord_x < box_max_x_ff[p_idx])
                  && (box_min_y_ff[p_idx] < req_data.coord_y)
                  && (req_data.coord_y < box_max_y_ff[p_idx]);
   assign query_go = accept && is_query && p_ok && in_box && (n_sel != '0);

   // box and count tables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_POLYGONS; i++) begin
            box_min_x_ff[i] <= '0;
            box_max_x_ff[i] <= '0;
            box_min_y_ff[i] <= '0;
            box_max_y_ff[i] <= '0;
            count_tbl_ff[i] <= '0;
         end
      end else if (accept && !is_query && p_ok && v_ok) begin
         count_tbl_ff[p_idx] <= CNT_W'(req_data.vertex_number) + CNT_W'(1);
         if (req_data.vertex_number == '0) begin
            box_min_x_ff[p_idx] <= req_data.coord_x;
            box_max_x_ff[p_idx] <= req_data.coord_x;
            box_min_y_ff[p_idx] <= req_data.coord_y;
            box_max_y_ff[p_idx] <= req_data.coord_y;
         end else begin
            if (req_data.coord_x < box_min_x_ff[p_idx]) box_min_x_ff[p_idx] <= req_data.coord_x;
            if (req_data.coord_x > box_max_x_ff[p_idx]) box_max_x_ff[p_idx] <= req_data.coord_x;
            if (req_data.coord_y < box_min_y_ff[p_idx]) box_min_y_ff[p_idx] <= req_data.coord_y;
            if (req_data.coord_y > box_max_y_ff[p_idx]) box_max_y_ff[p_idx] <= req_data.coord_y;
         end
      end
   end

   // vertex memory, x in the upper half
   logic [2*COORD_W-1:0] vmem [DEPTH];
   logic [2*COORD_W-1:0] rdata_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 rd_en;

   always_ff @(posedge clock) begin
      if (accept && !is_query && p_ok && v_ok) begin
         vmem[wr_addr] <= {req_data.coord_x, req_data.coord_y};
      end
      if (rd_en) begin
         rdata_ff <= vmem[rd_addr];
      end
   end

   // query registers and walk counter
   query_type         query_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [CNT_W-1:0]  n_ff, j_ff, j_in;
   logic              last_rd;

   always_ff @(posedge clock) begin
      if (accept && is_query) begin
         query_ff <= '{x: req_data.coord_x, y: req_data.coord_y, rx: ref_x_ff, ry: ref_y_ff};
         base_ff  <= base_sel;
         n_ff     <= n_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= '0;
      end else begin
         j_ff <= j_in;
      end
   end

   assign rd_addr = base_ff + ADDR_W'(j_ff);
   assign last_rd = (j_ff == n_ff - CNT_W'(1));

   // edge emitter: pairs consecutive vertices and closes back to vertex 0
   logic                 rd_vld_ff, rd_first_ff, rd_last_ff, close_ff;
   logic [2*COORD_W-1:0] first_ff, prev_ff;
   logic                 edge_vld_ff;
   edge_type             edge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         close_ff    <= 1'b0;
         edge_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= rd_en;
         edge_vld_ff <= 1'b0;
         if (rd_vld_ff) begin
            if (!rd_first_ff) begin
               edge_vld_ff <= 1'b1;
            end
            close_ff <= rd_last_ff;
         end else if (close_ff) begin
            edge_vld_ff <= 1'b1;
            close_ff    <= 1'b0;
         end
      end
      rd_first_ff <= (j_ff == '0);
      rd_last_ff  <= last_rd;
      if (rd_vld_ff) begin
         prev_ff <= rdata_ff;
         if (rd_first_ff) first_ff <= rdata_ff;
         edge_ff <= '{px: prev_ff[2*COORD_W-1:COORD_W], py: prev_ff[COORD_W-1:0],
                      qx: rdata_ff[2*COORD_W-1:COORD_W], qy: rdata_ff[COORD_W-1:0]};
      end else if (close_ff) begin
         edge_ff <= '{px: prev_ff[2*COORD_W-1:COORD_W], py: prev_ff[COORD_W-1:0],
                      qx: first_ff[2*COORD_W-1:COORD_W], qy: first_ff[COORD_W-1:0]};
      end
   end

   // edge crossing pipeline
   logic cross_vld, crossed, et_busy;

   pipc_edge_test u_edge_test (
      .clock,
      .reset,
      .edge_vld (edge_vld_ff),
      .edge_in  (edge_ff),
      .query    (query_ff),
      .cross_vld,
      .crossed,
      .busy     (et_busy)
   );

   // crossing counter, saturating, with true parity
   logic [COUNT_W-1:0] count_ff;
   logic               parity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         parity_ff <= 1'b0;
      end else if (accept && is_query) begin
         count_ff  <= '0;
         parity_ff <= 1'b0;
      end else if (cross_vld && crossed) begin
         parity_ff <= !parity_ff;
         if (count_ff != '1) count_ff <= count_ff + COUNT_W'(1);
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            j_in = '0;
            if (query_go) begin
               state_in = ST_WALK;
            end else if (accept && is_query) begin
               state_in = ST_RESULT;
            end
         end
         ST_WALK: begin
            rd_en = 1'b1;
            j_in  = j_ff + CNT_W'(1);
            if (last_rd) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!rd_vld_ff && !close_ff && !edge_vld_ff && !et_busy) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result beat
   assign rsp_strobe = (state_ff == ST_RESULT);
   assign rsp_data   = '{inside_res: parity_ff, crossing_count: count_ff};

   // checks
   a_result_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT) |=> (state_ff == ST_IDLE))
      else $error("result state lasted more than one cycle");

   a_query_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command == CMD_QUERY) |=> busy)
      else $error("accepted query did not make the block busy");

   a_close_in_flush: assert property (@(posedge clock) disable iff (reset)
      close_ff |-> (state_ff == ST_FLUSH))
      else $error("closing edge pending outside flush");

   a_result_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!edge_vld_ff && !et_busy && !rd_vld_ff))
      else $error("result shown while edges still in flight");

endmodule
`default_nettype wire

>>> hw/rtl/pipc_cross_cell.sv
// cross-product cell: r = a*b - c*d over two register stages
`default_nettype none
module pipc_cross_cell
   import pipc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [DIFF_W-1:0] a,
   input  wire logic signed [DIFF_W-1:0] b,
   input  wire logic signed [DIFF_W-1:0] c,
   input  wire logic signed [DIFF_W-1:0] d,
   output logic signed [NUM_W-1:0]       r
);

   logic signed [PROD_W-1:0] prod_ab_ff, prod_cd_ff;
   logic signed [NUM_W-1:0]  r_ff;

   // products, then difference
   always_ff @(posedge clock) begin
      prod_ab_ff <= a * b;
      prod_cd_ff <= c * d;
      r_ff       <= {prod_ab_ff[PROD_W-1], prod_ab_ff}
                  - {prod_cd_ff[PROD_W-1], prod_cd_ff};
   end

   assign r = r_ff;

endmodule
`default_nettype wire

>>> hw/rtl/pipc_edge_test.sv
// pipelined edge crossing test built from a row of cross-product cells
`default_nettype none
module pipc_edge_test
   import pipc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      edge_vld,
   input  wire edge_type  edge_in,
   input  wire query_type query,
   output logic           cross_vld,
   output logic           crossed,
   output logic           busy
);

   logic signed [DIFF_W-1:0] da_ff, db_ff, dc_ff, de_ff, df_ff, dg_ff;
   logic signed [NUM_W-1:0]  den, num_s, num_t;
   logic [2:0]               vld_ff;
   logic                     cross_vld_ff, cross_ff;

   function automatic logic signed [DIFF_W-1:0] sub(input logic signed [COORD_W-1:0] u,
                                                   input logic signed [COORD_W-1:0] v);
      return {u[COORD_W-1], u} - {v[COORD_W-1], v};
   endfunction

   // coordinate differences
   always_ff @(posedge clock) begin
      da_ff <= sub(edge_in.qx, edge_in.px);
      db_ff <= sub(query.y, query.ry);
      dc_ff <= sub(edge_in.qy, edge_in.py);
      de_ff <= sub(query.x, query.rx);
      df_ff <= sub(edge_in.py, query.y);
      dg_ff <= sub(edge_in.px, query.x);
   end

   // denominator and the two numerators
   pipc_cross_cell u_cell_d (.clock, .a(da_ff), .b(db_ff), .c(dc_ff), .d(de_ff), .r(den));
   pipc_cross_cell u_cell_s (.clock, .a(de_ff), .b(df_ff), .c(db_ff), .d(dg_ff), .r(num_s));
   pipc_cross_cell u_cell_t (.clock, .a(dg_ff), .b(dc_ff), .c(df_ff), .d(da_ff), .r(num_t));

   // valid tracking and final compare
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         cross_vld_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[1:0], edge_vld};
         cross_vld_ff <= vld_ff[2];
      end
      cross_ff <= (den != '0) && ratio_ok(num_s, den) && ratio_ok(num_t, den);
   end

   assign cross_vld = cross_vld_ff;
   assign crossed   = cross_ff;
   assign busy      = (|vld_ff) | cross_vld_ff;

endmodule
`default_nettype wire

>>> tb/sv/point_in_polygon_crossing_top_test.sv
// self-checking testbench for the point-in-polygon crossing block
`default_nettype none
module point_in_polygon_crossing_top_test;
   import pipc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  NUM_POLY   = 16;
   localparam int  NUM_VERT   = 128;
   localparam int  ONE_DEG    = 1 << 20;
   localparam int  COORD_MIN  = 32'sh8000_0000;
   localparam int  COORD_MAX  = 32'sh7fff_ffff;
   localparam int  ITEM_GOAL  = 500;
   localparam int  DRAIN_WAIT = 140;
   localparam longint CYCLE_LIMIT = 1_000_000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [0:0] csr_index;
   logic [COORD_W-1:0] csr_wdata;

   point_in_polygon_crossing_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // polygon store as the block should hold it
   int         shadow_x [NUM_POLY][NUM_VERT];
   int         shadow_y [NUM_POLY][NUM_VERT];
   int         written_len [NUM_POLY];
   int         vert_count [NUM_POLY];
   int         box_lo_x [NUM_POLY];
   int         box_hi_x [NUM_POLY];
   int         box_lo_y [NUM_POLY];
   int         box_hi_y [NUM_POLY];
   int         outside_x;
   int         outside_y;

   rsp_type    pending_answers[$];
   int         mismatch_count;
   int         items_sent;
   int         queries_sent;
   int         answers_seen;
   int         csr_writes;
   int         gap_mode;
   longint     cycle_count = 0;

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type want;
   } stim_row_type;
   stim_row_type directed_rows[$];

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("point_in_polygon_crossing_top_test NOT OK");
         $finish;
      end
   end

   // exact signed product
   function automatic logic signed [127:0] wide_mul(longint a, longint b);
      logic signed [127:0] wa, wb;
      wa = a;
      wb = b;
      return wa * wb;
   endfunction

   // 0 < n/d <= 1 without division
   function automatic bit in_unit_range(logic signed [127:0] n, logic signed [127:0] d);
      if (n == 0) return 1'b0;
      if (d >= 0) return (n > 0) && (n <= d);
      return (n < 0) && (d <= n);
   endfunction

   function automatic bit edge_crosses(longint px, longint py, longint qx, longint qy,
                                       longint x, longint y);
      logic signed [127:0] d, ns, nt;
      longint rx, ry;
      rx = outside_x;
      ry = outside_y;
      d = wide_mul(qx - px, y - ry) - wide_mul(qy - py, x - rx);
      if (d == 0) return 1'b0;
      ns = wide_mul(x - rx, py - y) - wide_mul(y - ry, px - x);
      nt = wide_mul(px - x, qy - py) - wide_mul(py - y, qx - px);
      return in_unit_range(ns, d) && in_unit_range(nt, d);
   endfunction

   // crossing count for one query
   function automatic rsp_type count_crossings(req_type r);
      rsp_type res;
      int p, n, k, hits;
      p = r.polygon_number;
      res = '0;
      if (box_lo_x[p] < r.coord_x && r.coord_x < box_hi_x[p] &&
          box_lo_y[p] < r.coord_y && r.coord_y < box_hi_y[p]) begin
         n = vert_count[p];
         hits = 0;
         for (int j = 0; j < n; j++) begin
            k = (j + 1 < n) ? j + 1 : 0;
            if (edge_crosses(shadow_x[p][j], shadow_y[p][j], shadow_x[p][k],
                             shadow_y[p][k], r.coord_x, r.coord_y))
               hits++;
         end
         res.inside_res = hits[0];
         res.crossing_count = (hits > 255) ? 8'd255 : hits[7:0];
      end
      return res;
   endfunction

   function automatic void store_vertex(req_type r);
      int p, v;
      p = r.polygon_number;
      v = r.vertex_number;
      shadow_x[p][v] = r.coord_x;
      shadow_y[p][v] = r.coord_y;
      if (v == written_len[p]) written_len[p]++;
      if (v == 0) begin
         box_lo_x[p] = r.coord_x;
         box_hi_x[p] = r.coord_x;
         box_lo_y[p] = r.coord_y;
         box_hi_y[p] = r.coord_y;
      end else begin
         if (r.coord_x < box_lo_x[p]) box_lo_x[p] = r.coord_x;
         if (r.coord_x > box_hi_x[p]) box_hi_x[p] = r.coord_x;
         if (r.coord_y < box_lo_y[p]) box_lo_y[p] = r.coord_y;
         if (r.coord_y > box_hi_y[p]) box_hi_y[p] = r.coord_y;
      end
      vert_count[p] = v + 1;
   endfunction

   function automatic int pick_between(longint lo, longint hi);
      longint span, raw;
      span = hi - lo + 1;
      raw = {$urandom, $urandom};
      raw = raw & 64'h7fff_ffff_ffff_ffff;
      return int'(lo + raw % span);
   endfunction

   function automatic req_type make_req(logic cmd, int p, int v, int x, int y);
      req_type r;
      r.command = cmd;
      r.polygon_number = p[3:0];
      r.vertex_number = v[6:0];
      r.coord_x = x;
      r.coord_y = y;
      return r;
   endfunction

   // drive one beat and book its answer once it is taken
   task automatic send_item(req_type r, bit fixed, rsp_type want);
      int gap;
      gap = (gap_mode == 0) ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      if (r.command == CMD_LOAD) begin
         store_vertex(r);
      end else begin
         queries_sent++;
         pending_answers.push_back(fixed ? want : count_crossings(r));
      end
   endtask

   // wait for the block to go quiet, then write one register
   task automatic write_reference(csr_reg_type idx, int value);
      @(negedge clock);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      if (idx == REG_REFERENCE_X) outside_x = value;
      else outside_y = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // answer checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected answer inside=%0d count=%0d",
                        rsp_data.inside_res, rsp_data.crossing_count);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.inside_res !== want.inside_res ||
                rsp_data.crossing_count !== want.crossing_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("answer mismatch: expected inside=%0d count=%0d, got %0d %0d",
                           want.inside_res, want.crossing_count,
                           rsp_data.inside_res, rsp_data.crossing_count);
            end
         end
      end
   end

   function automatic void add_row(req_type r, bit fixed, logic in_poly, int cnt);
      stim_row_type row;
      row.item = r;
      row.fixed = fixed;
      row.want.inside_res = in_poly;
      row.want.crossing_count = cnt[7:0];
      directed_rows.push_back(row);
   endfunction

   initial begin
      req_type r;
      rsp_type none;
      int p, k, cx, cy, rad, nq, lo, hi, phase;
      bit wide_scale;
      int ref_pick;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = REG_REFERENCE_X;
      csr_wdata = '0;
      mismatch_count = 0;
      items_sent = 0;
      queries_sent = 0;
      answers_seen = 0;
      csr_writes = 0;
      gap_mode = 1;
      none = '0;
      outside_x = 0;
      outside_y = 0;
      for (int i = 0; i < NUM_POLY; i++) begin
         written_len[i] = 0;
         vert_count[i] = 0;
         box_lo_x[i] = 0;
         box_hi_x[i] = 0;
         box_lo_y[i] = 0;
         box_hi_y[i] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed stimulus
      add_row(make_req(CMD_QUERY, 0, 0, 0, 0), 1, 0, 0);
      add_row(make_req(CMD_QUERY, 15, 127, COORD_MAX, COORD_MIN), 1, 0, 0);
      add_row(make_req(CMD_LOAD, 1, 0, -10 * ONE_DEG, -10 * ONE_DEG), 0, 0, 0);
      add_row(make_req(CMD_LOAD, 1, 1, 10 * ONE_DEG, -10 * ONE_DEG), 0, 0, 0);
      add_row(make_req(CMD_LOAD, 1, 2, 10 * ONE_DEG, 10 * ONE_DEG), 0, 0, 0);
      add_row(make_req(CMD_LOAD, 1, 3, -10 * ONE_DEG, 10 * ONE_DEG), 0, 0, 0);
      add_row(make_req(CMD_QUERY, 1, 0, 0, 0), 0, 0, 0);
      // point on the box border is not strictly inside
      add_row(make_req(CMD_QUERY, 1, 0, 10 * ONE_DEG, 0), 1, 0, 0);
      add_row(make_req(CMD_QUERY, 1, 0, -10 * ONE_DEG + 1, 10 * ONE_DEG - 1), 0, 0, 0);
      add_row(make_req(CMD_LOAD, 2, 0, COORD_MIN, COORD_MIN), 0, 0, 0);
      add_row(make_req(CMD_LOAD, 2, 1, COORD_MAX, COORD_MIN), 0, 0, 0);
      add_row(make_req(CMD_LOAD, 2, 2, 0, COORD_MAX), 0, 0, 0);
      add_row(make_req(CMD_QUERY, 2, 0, 0, 0), 0, 0, 0);
      add_row(make_req(CMD_QUERY, 2, 0, COORD_MAX, 0), 1, 0, 0);
      // zero-length edge from a repeated vertex
      add_row(make_req(CMD_LOAD, 3, 0, 0, 0), 0, 0, 0);
      add_row(make_req(CMD_LOAD, 3, 1, 0, 0), 0, 0, 0);
      add_row(make_req(CMD_LOAD, 3, 2, 4 * ONE_DEG, 0), 0, 0, 0);
      add_row(make_req(CMD_LOAD, 3, 3, 0, 4 * ONE_DEG), 0, 0, 0);
      add_row(make_req(CMD_QUERY, 3, 0, ONE_DEG, ONE_DEG), 0, 0, 0);
      add_row(make_req(CMD_QUERY, 3, 0, 2 * ONE_DEG, 2 * ONE_DEG), 0, 0, 0);
      // reloading vertex 0 restarts the box
      add_row(make_req(CMD_LOAD, 1, 0, 5 * ONE_DEG, 5 * ONE_DEG), 0, 0, 0);
      add_row(make_req(CMD_QUERY, 1, 0, 5 * ONE_DEG, 5 * ONE_DEG), 1, 0, 0);

      foreach (directed_rows[i]) begin
         if (i == 2) begin
            // reference far outside, from the corner
            write_reference(REG_REFERENCE_X, COORD_MIN);
            write_reference(REG_REFERENCE_Y, COORD_MIN + 7);
         end
         send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
      end

      // random phases: build one polygon, then query it
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         phase++;
         gap_mode = (phase % 4 == 0) ? 0 : 1;
         if (phase % 3 == 0) begin
            ref_pick = $urandom_range(0, 5);
            case (ref_pick)
               0: begin
                  write_reference(REG_REFERENCE_X, COORD_MIN);
                  write_reference(REG_REFERENCE_Y, COORD_MIN);
               end
               1: begin
                  write_reference(REG_REFERENCE_X, COORD_MAX);
                  write_reference(REG_REFERENCE_Y, COORD_MAX);
               end
               2: begin
                  write_reference(REG_REFERENCE_X, COORD_MIN);
                  write_reference(REG_REFERENCE_Y, COORD_MAX);
               end
               3: begin
                  write_reference(REG_REFERENCE_X, COORD_MAX);
                  write_reference(REG_REFERENCE_Y, 0);
               end
               default: begin
                  write_reference(REG_REFERENCE_X, int'($urandom));
                  write_reference(REG_REFERENCE_Y, int'($urandom));
               end
            endcase
         end
         p = $urandom_range(0, NUM_POLY - 1);
         k = (phase == 3 || phase == 17) ? NUM_VERT : $urandom_range(3, 10);
         wide_scale = ($urandom_range(0, 3) == 0);
         rad = 1 << $urandom_range(10, 26);
         cx = pick_between(-(1 << 30), 1 << 30);
         cy = pick_between(-(1 << 30), 1 << 30);
         // occasionally a broken load sequence
         if ($urandom_range(0, 9) == 0) k = $urandom_range(1, 2);
         for (int v = 0; v < k; v++) begin
            if (wide_scale)
               r = make_req(CMD_LOAD, p, v, int'($urandom), int'($urandom));
            else
               r = make_req(CMD_LOAD, p, v, pick_between(cx - rad, cx + rad),
                            pick_between(cy - rad, cy + rad));
            send_item(r, 0, none);
         end
         // rewrite one vertex already in the prefix
         if ($urandom_range(0, 7) == 0) begin
            r = make_req(CMD_LOAD, p, $urandom_range(0, written_len[p] - 1),
                         int'($urandom), int'($urandom));
            send_item(r, 0, none);
         end
         nq = $urandom_range(2, 8);
         for (int q = 0; q < nq; q++) begin
            if ($urandom_range(0, 5) == 0) begin
               r = make_req(CMD_QUERY, $urandom_range(0, NUM_POLY - 1), $urandom_range(0, 127),
                            int'($urandom), int'($urandom));
            end else if (box_hi_x[p] - longint'(box_lo_x[p]) >= 2 &&
                         box_hi_y[p] - longint'(box_lo_y[p]) >= 2) begin
               lo = box_lo_x[p];
               hi = box_hi_x[p];
               r = make_req(CMD_QUERY, p, $urandom_range(0, 127),
                            pick_between(longint'(lo) + 1, longint'(hi) - 1), 0);
               r.coord_y = pick_between(longint'(box_lo_y[p]) + 1, longint'(box_hi_y[p]) - 1);
            end else begin
               r = make_req(CMD_QUERY, p, 0, int'($urandom), int'($urandom));
            end
            send_item(r, 0, none);
         end
      end

      // drain
      @(negedge clock);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d items (%0d queries) over %0d phases, %0d register writes",
               items_sent, queries_sent, phase, csr_writes);
      $display("checked %0d answers, %0d mismatches", answers_seen, mismatch_count);
      if (mismatch_count == 0 && pending_answers.size() == 0)
         $display("point_in_polygon_crossing_top_test OK");
      else
         $display("point_in_polygon_crossing_top_test NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/pipc_pkg.sv
hw/rtl/pipc_cross_cell.sv
hw/rtl/pipc_edge_test.sv
hw/rtl/point_in_polygon_crossing_top.sv
tb/sv/point_in_polygon_crossing_top_test.sv
